@@ rtl/rbba_pkg.sv @@
// Package for the ring block buffer allocator: widths, op and state codes,
// and the structs passed between the front end, the op queue and the back end.
`default_nettype none
package rbba_pkg;
  localparam int MaxBlocks = 16;
  localparam int IdW = 4;
  localparam int CntW = 5;
  localparam int FieldW = 24;
  localparam logic [FieldW-1:0] FieldMax = 24'hFFFFFF;
  localparam logic [FieldW-1:0] BufSizeReset = 24'd4096;

  typedef enum logic [2:0] {
    OP_ALLOC = 3'd0, OP_PUT = 3'd1, OP_GET = 3'd2, OP_FREE = 3'd3,
    OP_QGET = 3'd4, OP_QPEEK = 3'd5, OP_BAD6 = 3'd6, OP_BAD7 = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_UNUSED = 2'd0, ST_INITED = 2'd1, ST_PUT = 2'd2, ST_GOT = 2'd3
  } blk_state_t;

  // classified command from the front end
  typedef struct packed {
    op_t               op;
    logic [IdW-1:0]    block_id;
    logic [FieldW-1:0] size;
  } cmd_t;

  typedef struct packed {
    logic              ok;
    logic [IdW-1:0]    block_id;
    logic [FieldW-1:0] offset;
    logic [FieldW-1:0] length;
    logic [CntW-1:0]   block_count;
  } rsp_t;

  typedef enum logic [2:0] {
    BE_IDLE, BE_SCAN, BE_RUN, BE_MARK, BE_COMPACT, BE_DONE
  } be_state_t;
endpackage
`default_nettype wire

@@ rtl/rbba_if.sv @@
// Valid/ready channel interfaces for the allocator's request and result.
// Depends on rbba_pkg.
`default_nettype none
interface rbba_req_if;
  import rbba_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [2:0]           op;
  logic [IdW-1:0]       block_id;
  logic [FieldW-1:0]    size;
  modport source (output valid, output op, output block_id, output size, input ready);
  modport sink   (input valid, input op, input block_id, input size, output ready);
endinterface

interface rbba_rsp_if;
  import rbba_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 ok;
  logic [IdW-1:0]       out_block_id;
  logic [FieldW-1:0]    offset;
  logic [FieldW-1:0]    length;
  logic [CntW-1:0]      block_count;
  modport source (output valid, output ok, output out_block_id, output offset,
                  output length, output block_count, input ready);
  modport sink   (input valid, input ok, input out_block_id, input offset,
                  input length, input block_count, output ready);
endinterface
`default_nettype wire

@@ rtl/rbba_front.sv @@
// Front end: accept request transactions, classify the op, and push commands
// into a two-entry queue toward the back end. Depends on rbba_pkg.
`default_nettype none
module rbba_front
  import rbba_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [2:0]       in_op,
  input  wire logic [IdW-1:0]   in_block_id,
  input  wire logic [FieldW-1:0] in_size,
  output logic                  cmd_valid,
  input  wire logic             cmd_pop,
  output cmd_t                  cmd
);
  cmd_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, wr_r;
  logic       push;
  cmd_t       c;

  always_comb begin
    c.op = op_t'(in_op);
    c.block_id = in_block_id;
    // size only matters for alloc and queue_get; zero it otherwise
    c.size = (in_op == OP_ALLOC || in_op == OP_QGET) ? in_size : '0;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push = in_valid && in_ready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd = q_r[rd_r];
  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, cmd_pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= ~wr_r;
      if (cmd_pop) rd_r <= ~rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= c;
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n) cmd_pop |-> cmd_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !cmd_pop) |=> cnt_r == 2'd2)
    else $error("full queue lost an entry");
endmodule
`default_nettype wire

@@ rtl/rbba_back.sv @@
// Back end: descriptor tables, free stack and ordered list; executes one
// command at a time with a sequencer that walks the list. Depends on rbba_pkg.
`default_nettype none
module rbba_back
  import rbba_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [FieldW-1:0] ring_bytes,
  input  wire logic             cmd_valid,
  output logic                  cmd_pop,
  input  cmd_t                  cmd,
  output logic                  rsp_valid,
  input  wire logic             rsp_ready,
  output rsp_t                  rsp
);
  blk_state_t        bst_r [MaxBlocks];
  logic [FieldW-1:0] boff_r [MaxBlocks];
  logic [FieldW-1:0] blen_r [MaxBlocks];
  logic [IdW-1:0]    ord_r [MaxBlocks];
  logic [IdW-1:0]    fstk_r [MaxBlocks];
  logic [CntW-1:0]   ocnt_r, fcnt_r;

  be_state_t         st_r, st_nxt;
  cmd_t              cur_r;
  logic [CntW-1:0]   idx_r, idx_nxt;     // list walk position
  logic [CntW-1:0]   first_r, first_nxt; // run start
  logic [CntW-1:0]   n_r, n_nxt;         // run count
  logic [FieldW:0]   sum_r, sum_nxt;     // run total, saturating
  logic [IdW-1:0]    last_r, last_nxt;
  rsp_t              res_r, res_nxt;
  logic              rv_r;

  logic [IdW-1:0]    cid;
  logic              in_list;
  logic [IdW-1:0]    hid, tid, aid;
  logic [FieldW:0]   tend_w;
  logic [FieldW-1:0] tend, gap_t, gap_h;
  logic              placed;
  logic [FieldW-1:0] at;
  logic [FieldW+1:0] sum_add;
  logic              tbl_we;   // alloc write
  logic              put_we, got_we, free_we, mark_we;
  logic [IdW-1:0]    got_id;

  assign rsp_valid = rv_r;
  assign rsp = res_r;
  assign in_list = idx_r < ocnt_r;
  assign cid = ord_r[idx_r[IdW-1:0]];

  // alloc placement
  always_comb begin
    hid = ord_r[0];
    tid = ord_r[IdW'(ocnt_r - 5'd1)];
    aid = fstk_r[IdW'(fcnt_r - 5'd1)];
    tend_w = {1'b0, boff_r[tid]} + {1'b0, blen_r[tid]};
    tend = tend_w[FieldW] ? FieldMax : tend_w[FieldW-1:0];
    gap_t = (ring_bytes > tend) ? ring_bytes - tend : '0;
    gap_h = (boff_r[hid] > tend) ? boff_r[hid] - tend : '0;
    placed = 1'b0;
    at = '0;
    if (ocnt_r == '0) begin
      placed = cur_r.size <= ring_bytes;
    end else if (boff_r[hid] <= boff_r[tid]) begin
      if (gap_t >= cur_r.size) begin
        placed = 1'b1; at = tend;
      end else if (boff_r[hid] >= cur_r.size) begin
        placed = 1'b1;
      end
    end else if (gap_h >= cur_r.size) begin
      placed = 1'b1; at = tend;
    end
    sum_add = {1'b0, sum_r} + {2'b0, blen_r[cid]};
  end

  always_comb begin
    st_nxt = st_r;
    idx_nxt = idx_r;
    first_nxt = first_r;
    n_nxt = n_r;
    sum_nxt = sum_r;
    last_nxt = last_r;
    res_nxt = res_r;
    cmd_pop = 1'b0;
    tbl_we = 1'b0;
    put_we = 1'b0;
    got_we = 1'b0;
    free_we = 1'b0;
    mark_we = 1'b0;
    got_id = cid;
    unique case (st_r)
      BE_IDLE: begin
        if (cmd_valid && !rv_r) begin
          cmd_pop = 1'b1;
          idx_nxt = '0;
          res_nxt = '0;
          st_nxt = BE_SCAN;
        end
      end
      BE_SCAN: begin
        // cur_r valid from here on
        st_nxt = BE_DONE;
        priority case (cur_r.op)
          OP_ALLOC: begin
            if (fcnt_r != '0 && placed && ocnt_r < CntW'(MaxBlocks)) begin
              tbl_we = 1'b1;
              res_nxt = '{1'b1, aid, at, cur_r.size, '0};
            end
          end
          OP_PUT: begin
            if (bst_r[cur_r.block_id] == ST_INITED) begin
              put_we = 1'b1;
              res_nxt = '{1'b1, cur_r.block_id, boff_r[cur_r.block_id],
                          blen_r[cur_r.block_id], '0};
            end
          end
          OP_FREE: begin
            if (bst_r[cur_r.block_id] != ST_UNUSED) begin
              res_nxt = '{1'b1, cur_r.block_id, boff_r[cur_r.block_id],
                          blen_r[cur_r.block_id], '0};
              idx_nxt = '0;
              first_nxt = '0;
              st_nxt = BE_COMPACT;
            end
          end
          OP_GET, OP_QGET, OP_QPEEK: begin
            // walk one list entry a cycle looking for a ready block
            if (in_list) begin
              st_nxt = BE_SCAN;
              idx_nxt = idx_r + 5'd1;
              if (bst_r[cid] == ST_PUT) begin
                res_nxt = '{1'b1, cid, boff_r[cid], blen_r[cid], '0};
                if (cur_r.op == OP_GET) begin
                  got_we = 1'b1;
                  st_nxt = BE_DONE;
                end else begin
                  first_nxt = idx_r;
                  n_nxt = 5'd1;
                  sum_nxt = {1'b0, blen_r[cid]};
                  last_nxt = cid;
                  st_nxt = BE_RUN;
                end
              end
            end
          end
          default: ;
        endcase
      end
      BE_RUN: begin
        if (in_list && bst_r[cid] == ST_PUT && boff_r[last_r] <= boff_r[cid] &&
            !(cur_r.op == OP_QGET && sum_add > {2'b0, cur_r.size})) begin
          sum_nxt = sum_add[FieldW+1] ? {1'b1, FieldMax} : sum_add[FieldW:0];
          n_nxt = n_r + 5'd1;
          last_nxt = cid;
          idx_nxt = idx_r + 5'd1;
        end else begin
          res_nxt.length = sum_r[FieldW] ? FieldMax : sum_r[FieldW-1:0];
          res_nxt.block_count = n_r;
          idx_nxt = first_r;
          st_nxt = (cur_r.op == OP_QGET) ? BE_MARK : BE_DONE;
        end
      end
      BE_MARK: begin
        // claim the run one entry a cycle
        if (idx_r < first_r + n_r) begin
          mark_we = 1'b1;
          idx_nxt = idx_r + 5'd1;
        end else begin
          st_nxt = BE_DONE;
        end
      end
      BE_COMPACT: begin
        // idx_r reads, first_r writes; drop entries equal to the freed id
        if (in_list) begin
          idx_nxt = idx_r + 5'd1;
          if (cid != cur_r.block_id) first_nxt = first_r + 5'd1;
        end else begin
          free_we = 1'b1;
          st_nxt = BE_DONE;
        end
      end
      BE_DONE: begin
        st_nxt = BE_IDLE;
      end
      default: st_nxt = BE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BE_IDLE;
      rv_r <= 1'b0;
      ocnt_r <= '0;
      fcnt_r <= CntW'(MaxBlocks);
      for (int i = 0; i < MaxBlocks; i++) begin
        bst_r[i] <= ST_UNUSED;
        fstk_r[i] <= IdW'(i);
      end
    end else begin
      st_r <= st_nxt;
      if (st_r == BE_DONE) rv_r <= 1'b1;
      else if (rsp_ready) rv_r <= 1'b0;
      if (tbl_we) begin
        bst_r[aid] <= ST_INITED;
        ocnt_r <= ocnt_r + 5'd1;
        fcnt_r <= fcnt_r - 5'd1;
      end
      if (put_we) bst_r[cur_r.block_id] <= ST_PUT;
      if (got_we) bst_r[got_id] <= ST_GOT;
      if (mark_we) bst_r[cid] <= ST_GOT;
      if (free_we) begin
        bst_r[cur_r.block_id] <= ST_UNUSED;
        ocnt_r <= first_r;
        if (fcnt_r < CntW'(MaxBlocks)) begin
          fstk_r[fcnt_r[IdW-1:0]] <= cur_r.block_id;
          fcnt_r <= fcnt_r + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) cur_r <= cmd;
    idx_r <= idx_nxt;
    first_r <= first_nxt;
    n_r <= n_nxt;
    sum_r <= sum_nxt;
    last_r <= last_nxt;
    res_r <= res_nxt;
    if (tbl_we) begin
      boff_r[aid] <= at;
      blen_r[aid] <= cur_r.size;
      ord_r[ocnt_r[IdW-1:0]] <= aid;
    end
    if (st_r == BE_COMPACT && in_list && cid != cur_r.block_id)
      ord_r[first_r[IdW-1:0]] <= cid;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (ocnt_r + fcnt_r) <= CntW'(MaxBlocks))
    else $error("descriptor count mismatch");
  assert property (@(posedge clk) disable iff (!rst_n) cmd_pop |-> st_r == BE_IDLE)
    else $error("pop while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    (rv_r && !rsp_ready) |=> rv_r && $stable(res_r))
    else $error("result dropped");
endmodule
`default_nettype wire

@@ rtl/ring_block_buffer_allocator.sv @@
// Allocator top: size register, front queue, back sequencer (rbba_pkg, rbba_if, rbba_front,
// rbba_back). The back end executes one op at a time: scans walk the list entry by entry,
// queue runs then walk the run (queue_get also claims each entry of it), and free compacts
// the whole list; the front queue can hold further requests meanwhile. Reset (sync, rst_n low):
// descriptors unused, list empty, free stack full with highest id on top, buffer_size 4096.
`default_nettype none
module ring_block_buffer_allocator
  import rbba_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic              cfg_we,
  input  wire logic [FieldW-1:0] cfg_wdata,
  rbba_req_if.sink               in_ch,
  rbba_rsp_if.source             out_ch
);
  logic [FieldW-1:0] ring_bytes_r;
  logic cmd_valid, cmd_pop;
  cmd_t cmd;
  rsp_t rsp;

  // hold the buffer size; to be written only while idle, which the block itself does not enforce
  always_ff @(posedge clk) begin
    if (!rst_n) ring_bytes_r <= BufSizeReset;
    else if (cfg_we) ring_bytes_r <= cfg_wdata;
  end

  // accept and queue request transactions
  rbba_front u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_op(in_ch.op),
    .in_block_id(in_ch.block_id), .in_size(in_ch.size),
    .cmd_valid, .cmd_pop, .cmd
  );

  // execute commands against descriptor state
  rbba_back u_back (
    .clk, .rst_n, .ring_bytes(ring_bytes_r),
    .cmd_valid, .cmd_pop, .cmd,
    .rsp_valid(out_ch.valid), .rsp_ready(out_ch.ready), .rsp
  );

  assign out_ch.ok = rsp.ok;
  assign out_ch.out_block_id = rsp.block_id;
  assign out_ch.offset = rsp.offset;
  assign out_ch.length = rsp.length;
  assign out_ch.block_count = rsp.block_count;
endmodule
`default_nettype wire

@@ tb/sv/rbba_tb_if.sv @@
// Note: the block's own channel interfaces live in rtl/rbba_if.sv and are used
// as they are; this file holds only a small helper package for the testbench.
// Depends on rbba_pkg.
`timescale 1ns / 1ps
package rbba_tb_pkg;
  import rbba_pkg::*;
  typedef struct {
    op_t               op;
    logic [IdW-1:0]    block_id;
    logic [FieldW-1:0] size;
  } alloc_req_t;
endpackage

@@ tb/sv/ring_block_buffer_allocator_tb.sv @@
// Testbench for ring_block_buffer_allocator: drives random and directed
// allocator requests, predicts every result and compares field by field.
// Depends on rbba_pkg, rbba_if, rbba_tb_pkg and the allocator RTL.
`timescale 1ns / 1ps
module ring_block_buffer_allocator_tb;
  import rbba_pkg::*;
  import rbba_tb_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [FieldW-1:0] cfg_wdata = '0;

  rbba_req_if in_ch ();
  rbba_rsp_if out_ch ();

  ring_block_buffer_allocator uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #10 clk = ~clk;

  // Allocator shadow state
  blk_state_t        sh_state [MaxBlocks];
  logic [FieldW-1:0] sh_off [MaxBlocks];
  logic [FieldW-1:0] sh_len [MaxBlocks];
  int                sh_order [$];
  int                sh_free [$];
  logic [FieldW-1:0] sh_bufsize;

  alloc_req_t pending_reqs [$];
  rsp_t       expected_rsps [$];
  int  errors = 0;
  int  idle_pct = 23;   // idling rate for both sides; 0 during calm stretch
  bit  hold_rx = 0;     // long receiver hold-off for back-pressure
  bit  hold_go = 0;     // starts the hold-off process
  logic in_acc = 1'b0;  // request accepted at the last rising edge

  function automatic logic [FieldW-1:0] end_of(int id);
    logic [FieldW:0] e;
    e = {1'b0, sh_off[id]} + {1'b0, sh_len[id]};
    return (e > FieldMax) ? FieldMax : e[FieldW-1:0];
  endfunction

  function automatic logic [FieldW-1:0] gap_of(logic [FieldW-1:0] hi, logic [FieldW-1:0] lo);
    return (hi > lo) ? hi - lo : '0;
  endfunction

  // Compute the result of one request and advance the shadow state
  function automatic rsp_t predict_alloc(alloc_req_t r);
    rsp_t res;
    int id, h, t, f, n, last;
    bit placed;
    logic [FieldW-1:0] at, tend;
    longint sum;
    res = '0;
    placed = 0;
    at = '0;
    case (r.op)
      OP_ALLOC: begin
        if (sh_free.size() > 0) begin
          id = sh_free[$];
          if (sh_order.size() == 0) begin
            if (r.size <= sh_bufsize) placed = 1;
          end else begin
            h = sh_order[0];
            t = sh_order[$];
            tend = end_of(t);
            if (sh_off[h] <= sh_off[t]) begin
              if (gap_of(sh_bufsize, tend) >= r.size) begin
                placed = 1; at = tend;
              end else if (sh_off[h] >= r.size) begin
                placed = 1; at = '0;
              end
            end else if (gap_of(sh_off[h], tend) >= r.size) begin
              placed = 1; at = tend;
            end
          end
          if (placed) begin
            void'(sh_free.pop_back());
            sh_order.push_back(id);
            sh_state[id] = ST_INITED;
            sh_off[id] = at;
            sh_len[id] = r.size;
            res.ok = 1'b1; res.block_id = IdW'(id); res.offset = at; res.length = r.size;
          end
        end
      end
      OP_PUT: begin
        if (sh_state[r.block_id] == ST_INITED) begin
          sh_state[r.block_id] = ST_PUT;
          res.ok = 1'b1; res.block_id = r.block_id;
          res.offset = sh_off[r.block_id]; res.length = sh_len[r.block_id];
        end
      end
      OP_GET: begin
        foreach (sh_order[i]) begin
          id = sh_order[i];
          if (sh_state[id] == ST_PUT) begin
            sh_state[id] = ST_GOT;
            res.ok = 1'b1; res.block_id = IdW'(id);
            res.offset = sh_off[id]; res.length = sh_len[id];
            break;
          end
        end
      end
      OP_FREE: begin
        if (sh_state[r.block_id] != ST_UNUSED) begin
          for (int i = sh_order.size() - 1; i >= 0; i--)
            if (sh_order[i] == r.block_id) sh_order.delete(i);
          sh_state[r.block_id] = ST_UNUSED;
          if (sh_free.size() < MaxBlocks) sh_free.push_back(r.block_id);
          res.ok = 1'b1; res.block_id = r.block_id;
          res.offset = sh_off[r.block_id]; res.length = sh_len[r.block_id];
        end
      end
      OP_QGET, OP_QPEEK: begin
        f = -1;
        foreach (sh_order[i]) if (f < 0 && sh_state[sh_order[i]] == ST_PUT) f = i;
        if (f >= 0) begin
          last = sh_order[f];
          sum = sh_len[last];
          n = 1;
          for (int i = f + 1; i < sh_order.size(); i++) begin
            id = sh_order[i];
            if (sh_state[id] != ST_PUT) break;
            if (sh_off[last] > sh_off[id]) break;
            if (r.op == OP_QGET && sum + sh_len[id] > longint'(r.size)) break;
            sum += sh_len[id];
            last = id;
            n++;
          end
          id = sh_order[f];
          res.ok = 1'b1; res.block_id = IdW'(id); res.offset = sh_off[id];
          res.length = (sum > FieldMax) ? FieldMax : sum[FieldW-1:0];
          res.block_count = CntW'(n);
          if (r.op == OP_QGET)
            for (int k = 0; k < n; k++) sh_state[sh_order[f + k]] = ST_GOT;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Record whether the offered request was taken at this rising edge
  always @(posedge clk) in_acc <= in_ch.valid && in_ch.ready;

  // Driver: hold the transaction until accepted, change at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_acc) begin
      // hold current transaction
    end else if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
      in_ch.valid <= 1'b1;
      in_ch.op <= pending_reqs[0].op;
      in_ch.block_id <= pending_reqs[0].block_id;
      in_ch.size <= pending_reqs[0].size;
      expected_rsps.push_back(predict_alloc(pending_reqs.pop_front()));
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Receiver readiness, with random idling and the long hold-off
  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= !hold_rx && ($urandom_range(99) >= idle_pct);
  end

  // Long receiver hold-off, counted here while the sender keeps offering
  initial begin
    wait (hold_go);
    hold_rx = 1;
    repeat (400) @(posedge clk);
    hold_rx = 0;
  end

  int    quiet_cycles = 0;

  // Monitor: sample at the rising edge and check against the oldest expectation
  always @(posedge clk) begin
    rsp_t want;
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (out_ch.valid && out_ch.ready) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected result ok=%0b id=%0d", $time, out_ch.ok,
                   out_ch.out_block_id);
          errors++;
        end else begin
          want = expected_rsps.pop_front();
          if (want.ok !== out_ch.ok || want.block_id !== out_ch.out_block_id ||
              want.offset !== out_ch.offset || want.length !== out_ch.length ||
              want.block_count !== out_ch.block_count) begin
            $display("%0t: mismatch expected ok=%0b id=%0d off=%0d len=%0d cnt=%0d",
                     $time, want.ok, want.block_id, want.offset, want.length,
                     want.block_count);
            $display("%0t:          actual   ok=%0b id=%0d off=%0d len=%0d cnt=%0d",
                     $time, out_ch.ok, out_ch.out_block_id, out_ch.offset,
                     out_ch.length, out_ch.block_count);
            errors++;
          end
        end
      end
      if (quiet_cycles > 5000) begin
        $display("%0t: watchdog expired", $time);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Add one request to the pending queue
  task automatic queue_req(op_t op, int id, int unsigned sz);
    alloc_req_t r;
    r.op = op;
    r.block_id = IdW'(id);
    r.size = FieldW'(sz);
    pending_reqs.push_back(r);
  endtask

  // Wait until every expectation is met, then let the back end settle
  task automatic drain();
    while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || in_ch.valid)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Write buffer_size while idle
  task automatic set_bufsize(logic [FieldW-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sh_bufsize = v;
  endtask

  // Random size, mostly scaled to the buffer
  function automatic int unsigned rand_size();
    int pick;
    pick = $urandom_range(99);
    if (pick < 5) return $urandom();
    if (pick < 10) return 0;
    if (pick < 15) return sh_bufsize;
    return $urandom_range((sh_bufsize / 4) + 1);
  endfunction

  // Phase of random traffic, mostly well-formed alloc/put/get/free flows
  task automatic random_phase(int count);
    int pick, id;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      id = $urandom_range(15);
      if (pick < 30) queue_req(OP_ALLOC, $urandom_range(15), rand_size());
      else if (pick < 50) queue_req(OP_PUT, id, $urandom());
      else if (pick < 60) queue_req(OP_GET, id, $urandom());
      else if (pick < 78) queue_req(OP_FREE, id, $urandom());
      else if (pick < 88) queue_req(OP_QGET, id, $urandom_range(1) ? $urandom() :
                                    $urandom_range(sh_bufsize));
      else if (pick < 96) queue_req(OP_QPEEK, id, $urandom());
      else queue_req($urandom_range(1) ? OP_BAD6 : OP_BAD7, id, $urandom());
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < MaxBlocks; i++) begin
      sh_state[i] = ST_UNUSED;
      sh_off[i] = '0;
      sh_len[i] = '0;
      sh_free.push_back(i);
    end
    sh_bufsize = BufSizeReset;
    in_ch.valid = 1'b0;
    in_ch.op = '0;
    in_ch.block_id = '0;
    in_ch.size = '0;
    out_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: nothing ready, bad descriptors, full fill, wrap, runs
    queue_req(OP_GET, 0, '0);
    queue_req(OP_QGET, 0, '0);
    queue_req(OP_QPEEK, 0, '0);
    queue_req(OP_PUT, 15, '0);
    queue_req(OP_FREE, 3, '0);
    queue_req(OP_ALLOC, 0, 24'd5000);           // larger than the buffer
    queue_req(OP_BAD6, 0, FieldMax);
    queue_req(OP_BAD7, 15, FieldMax);
    for (int i = 0; i < 4; i++) queue_req(OP_ALLOC, 0, 24'd1000);
    queue_req(OP_ALLOC, 0, 24'd200);            // no space
    for (int i = 12; i < 16; i++) queue_req(OP_PUT, i, '0);
    queue_req(OP_QPEEK, 0, '0);
    queue_req(OP_QGET, 0, 24'd10);              // first block above the limit
    queue_req(OP_QGET, 0, 24'd2000);
    queue_req(OP_FREE, 15, '0);
    queue_req(OP_FREE, 14, '0);
    queue_req(OP_ALLOC, 0, 24'd1500);           // placed at offset 0
    queue_req(OP_GET, 0, '0);
    drain();

    random_phase(400);
    set_bufsize(24'd1);
    random_phase(150);
    set_bufsize(FieldMax);
    // large blocks that saturate the run total
    for (int i = 0; i < 3; i++) queue_req(OP_ALLOC, 0, 24'h900000);
    random_phase(250);
    set_bufsize(24'd64);                         // shrink under live blocks
    idle_pct = 0;                                // calm stretch
    random_phase(300);
    idle_pct = 23;
    set_bufsize(24'd300);

    // Back-pressure: receiver holds off while the sender keeps offering
    hold_go = 1;
    for (int i = 0; i < 20; i++) queue_req(OP_QPEEK, 0, '0);
    @(posedge clk);
    wait (!hold_rx);
    random_phase(600);

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
